FILE: rtl/lpc_pkg.sv
package lpc_pkg;

    localparam int TICK_MS_DEF  = 1;
    localparam int DUTY_MAX_DEF = 8191;

    localparam int MS_W    = 15;
    localparam int LVL_W   = 7;
    localparam int DUTY_W  = 13;
    localparam int DIV_NW  = 22;
    localparam int DIV_QW  = 15;
    localparam int UPC_W   = 6;

    localparam int LEVEL_FULL = 100;
    localparam int RAMP_SCALE = 100;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_FADE  = 2'd3
    } t_mode;

    typedef enum logic {
        OPC_TICK = 1'b0,
        OPC_CMD  = 1'b1
    } t_opc;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_WAIT_DEC,
        OP_WAIT_CLR,
        OP_SET_OFF,
        OP_DIV_IV,
        OP_DIV_DU,
        OP_DIV_RAMP,
        OP_WAIT_Q,
        OP_LEVEL_Q,
        OP_STEP_INC,
        OP_SET_TOP,
        OP_STEP_DEC,
        OP_PERIOD_END,
        OP_ENTER,
        OP_STORE_PEND,
        OP_LOAD_CUR,
        OP_WRITE_OUT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACC,
        C_IS_CMD,
        C_STATIC,
        C_WAIT_LE1,
        C_IS_FADE,
        C_PHASE1,
        C_DIV_BUSY,
        C_DUR_ZERO,
        C_STEP_GE_DUR,
        C_STEP_ZERO,
        C_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic acc;
        logic is_cmd;
        logic is_static;
        logic wait_le1;
        logic is_fade;
        logic phase1;
        logic div_busy;
        logic dur_zero;
        logic step_ge_dur;
        logic step_zero;
        logic out_full;
    } t_stat;

    localparam logic [UPC_W-1:0] UA_IDLE  = 6'd0;
    localparam logic [UPC_W-1:0] UA_TWAIT = 6'd5;
    localparam logic [UPC_W-1:0] UA_FADE  = 6'd8;
    localparam logic [UPC_W-1:0] UA_TOP   = 6'd13;
    localparam logic [UPC_W-1:0] UA_DOWN  = 6'd14;
    localparam logic [UPC_W-1:0] UA_RAMPW = 6'd17;
    localparam logic [UPC_W-1:0] UA_WDIV  = 6'd19;
    localparam logic [UPC_W-1:0] UA_DIVW  = 6'd20;
    localparam logic [UPC_W-1:0] UA_PEND  = 6'd22;
    localparam logic [UPC_W-1:0] UA_ENTER = 6'd23;
    localparam logic [UPC_W-1:0] UA_EFADE = 6'd26;
    localparam logic [UPC_W-1:0] UA_CMD   = 6'd28;
    localparam logic [UPC_W-1:0] UA_CNOW  = 6'd30;
    localparam logic [UPC_W-1:0] UA_EMIT  = 6'd31;

    function automatic t_uword lpc_ucode(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '{OP_NOP, C_ALWAYS, UA_IDLE};
        unique case (pc)
            // wait for a word
            6'd0:  w = '{OP_NOP,        C_NO_ACC,      UA_IDLE};
            6'd1:  w = '{OP_NOP,        C_IS_CMD,      UA_CMD};
            // tick
            6'd2:  w = '{OP_NOP,        C_STATIC,      UA_EMIT};
            6'd3:  w = '{OP_NOP,        C_WAIT_LE1,    UA_TWAIT};
            6'd4:  w = '{OP_WAIT_DEC,   C_ALWAYS,      UA_EMIT};
            6'd5:  w = '{OP_WAIT_CLR,   C_IS_FADE,     UA_FADE};
            // blink
            6'd6:  w = '{OP_NOP,        C_PHASE1,      UA_PEND};
            6'd7:  w = '{OP_SET_OFF,    C_ALWAYS,      UA_WDIV};
            // fade
            6'd8:  w = '{OP_NOP,        C_DUR_ZERO,    UA_PEND};
            6'd9:  w = '{OP_NOP,        C_PHASE1,      UA_DOWN};
            6'd10: w = '{OP_STEP_INC,   C_NEVER,       UA_IDLE};
            6'd11: w = '{OP_NOP,        C_STEP_GE_DUR, UA_TOP};
            6'd12: w = '{OP_DIV_RAMP,   C_ALWAYS,      UA_RAMPW};
            6'd13: w = '{OP_SET_TOP,    C_ALWAYS,      UA_WDIV};
            6'd14: w = '{OP_STEP_DEC,   C_NEVER,       UA_IDLE};
            6'd15: w = '{OP_NOP,        C_STEP_ZERO,   UA_PEND};
            6'd16: w = '{OP_DIV_RAMP,   C_NEVER,       UA_IDLE};
            6'd17: w = '{OP_NOP,        C_DIV_BUSY,    UA_RAMPW};
            6'd18: w = '{OP_LEVEL_Q,    C_ALWAYS,      UA_WDIV};
            // wait from interval
            6'd19: w = '{OP_DIV_IV,     C_NEVER,       UA_IDLE};
            6'd20: w = '{OP_NOP,        C_DIV_BUSY,    UA_DIVW};
            6'd21: w = '{OP_WAIT_Q,     C_ALWAYS,      UA_EMIT};
            // end of period and mode entry
            6'd22: w = '{OP_PERIOD_END, C_NEVER,       UA_IDLE};
            6'd23: w = '{OP_ENTER,      C_STATIC,      UA_EMIT};
            6'd24: w = '{OP_NOP,        C_IS_FADE,     UA_EFADE};
            6'd25: w = '{OP_DIV_DU,     C_ALWAYS,      UA_DIVW};
            6'd26: w = '{OP_NOP,        C_DUR_ZERO,    UA_EMIT};
            6'd27: w = '{OP_NOP,        C_ALWAYS,      UA_WDIV};
            // command
            6'd28: w = '{OP_NOP,        C_STATIC,      UA_CNOW};
            6'd29: w = '{OP_STORE_PEND, C_ALWAYS,      UA_EMIT};
            6'd30: w = '{OP_LOAD_CUR,   C_ALWAYS,      UA_ENTER};
            // result word
            6'd31: w = '{OP_NOP,        C_OUT_FULL,    UA_EMIT};
            6'd32: w = '{OP_WRITE_OUT,  C_ALWAYS,      UA_IDLE};
            default: w = '{OP_NOP,      C_ALWAYS,      UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/lpc_in_if.sv
interface lpc_in_if
    import lpc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [1:0]        mode_req;
    logic [MS_W-1:0]   interval_ms;
    logic [MS_W-1:0]   duration_ms;

    modport source (output valid, opcode, mode_req, interval_ms, duration_ms, input ready);
    modport sink   (input valid, opcode, mode_req, interval_ms, duration_ms, output ready);
endinterface

FILE: rtl/lpc_out_if.sv
interface lpc_out_if
    import lpc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] pwm_duty;
    logic [LVL_W-1:0]  level_percent;
    logic [1:0]        active_mode;

    modport source (output valid, pwm_duty, level_percent, active_mode, input ready);
    modport sink   (input valid, pwm_duty, level_percent, active_mode, output ready);
endinterface

FILE: rtl/lpc_divider.sv
module lpc_divider
    import lpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [MS_W-1:0]   i_den,
    output logic              o_busy,
    output logic [DIV_QW-1:0] o_quot
);
    localparam int DSR_W = MS_W + DIV_QW - 1;
    localparam int CNT_W = $clog2(DIV_QW);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [DIV_QW-1:0] r_quot;
    logic              w_fit;

    assign w_fit = DSR_W'(r_rem) >= r_dsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_QW - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsr  <= {i_den, (DIV_QW-1)'(0)};
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dsr[DIV_NW-1:0];
            end
            r_quot <= {r_quot[DIV_QW-2:0], w_fit};
            r_dsr  <= r_dsr >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

FILE: rtl/lpc_sequencer.sv
module lpc_sequencer
    import lpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_op   o_op,
    output logic  o_idle
);
    logic [UPC_W-1:0] r_pc;
    logic [UPC_W-1:0] n_pc;
    t_uword           w_uw;
    logic             w_take;

    assign w_uw = lpc_ucode(r_pc);

    always_comb begin
        unique case (w_uw.cond)
            C_NEVER:       w_take = 1'b0;
            C_ALWAYS:      w_take = 1'b1;
            C_NO_ACC:      w_take = !i_stat.acc;
            C_IS_CMD:      w_take = i_stat.is_cmd;
            C_STATIC:      w_take = i_stat.is_static;
            C_WAIT_LE1:    w_take = i_stat.wait_le1;
            C_IS_FADE:     w_take = i_stat.is_fade;
            C_PHASE1:      w_take = i_stat.phase1;
            C_DIV_BUSY:    w_take = i_stat.div_busy;
            C_DUR_ZERO:    w_take = i_stat.dur_zero;
            C_STEP_GE_DUR: w_take = i_stat.step_ge_dur;
            C_STEP_ZERO:   w_take = i_stat.step_zero;
            C_OUT_FULL:    w_take = i_stat.out_full;
            default:       w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op   = w_uw.op;
    assign o_idle = r_pc == UA_IDLE;
endmodule

FILE: rtl/lpc_datapath.sv
module lpc_datapath
    import lpc_pkg::*;
#(
    parameter int TICK_MS  = TICK_MS_DEF,
    parameter int DUTY_MAX = DUTY_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic        i_idle,
    output t_stat       o_stat,
    lpc_in_if.sink      i_in,
    lpc_out_if.source   o_out
);
    localparam int TQ_SHIFT = MS_W + $clog2(TICK_MS);
    localparam int TQ_MUL   = ((1 << TQ_SHIFT) + TICK_MS - 1) / TICK_MS;
    localparam int TQ_PW    = MS_W + TQ_SHIFT + 1;

    logic                r_in_op;
    logic [1:0]          r_in_mode;
    logic [MS_W-1:0]     r_in_iv;
    logic [MS_W-1:0]     r_in_du;

    logic [1:0]          r_cur_mode;
    logic [MS_W-1:0]     r_cur_iv;
    logic [MS_W-1:0]     r_cur_du;
    logic                r_pend_valid;
    logic [1:0]          r_pend_mode;
    logic [MS_W-1:0]     r_pend_iv;
    logic [MS_W-1:0]     r_pend_du;
    logic                r_phase;
    logic [MS_W-1:0]     r_step;
    logic [MS_W-1:0]     r_wait;
    logic [LVL_W-1:0]    r_level;
    logic [MS_W-1:0]     r_tq;

    logic                r_out_valid;
    logic [DUTY_W-1:0]   r_out_duty;
    logic [LVL_W-1:0]    r_out_level;
    logic [1:0]          r_out_mode;

    logic                w_acc;
    logic                w_div_start;
    logic [DIV_NW-1:0]   w_div_num;
    logic [MS_W-1:0]     w_div_den;
    logic                w_div_busy;
    logic [DIV_QW-1:0]   w_div_quot;
    logic [MS_W-1:0]     w_tq_num;
    logic [TQ_PW-1:0]    w_tq_prd;
    logic [DUTY_W-1:0]   w_duty_lut [2**LVL_W];

    // duty table, one entry per level, clamped at full
    for (genvar g = 0; g < 2**LVL_W; g++) begin : g_duty
        localparam int LV     = (g > LEVEL_FULL) ? LEVEL_FULL : g;
        localparam int DUTY_G = (DUTY_MAX * LV) / LEVEL_FULL;
        assign w_duty_lut[g] = DUTY_W'(DUTY_G);
    end

    assign i_in.ready = i_idle && i_rst_n;
    assign w_acc      = i_in.valid && i_idle && i_rst_n;

    // ramp level by the serial divider
    assign w_div_start = i_op == OP_DIV_RAMP;
    assign w_div_num   = DIV_NW'(r_step) * DIV_NW'(RAMP_SCALE);
    assign w_div_den   = r_cur_du;

    // ms to ticks by reciprocal multiplication
    assign w_tq_num = (i_op == OP_DIV_DU) ? r_cur_du : r_cur_iv;
    assign w_tq_prd = TQ_PW'(w_tq_num) * TQ_PW'(TQ_MUL);

    lpc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in_op   <= i_in.opcode;
            r_in_mode <= i_in.mode_req;
            r_in_iv   <= i_in.interval_ms;
            r_in_du   <= i_in.duration_ms;
        end
        if (i_op == OP_DIV_IV || i_op == OP_DIV_DU) begin
            r_tq <= w_tq_prd[TQ_SHIFT +: MS_W];
        end
        if (i_op == OP_WRITE_OUT) begin
            r_out_duty  <= w_duty_lut[r_level];
            r_out_level <= r_level;
            r_out_mode  <= r_cur_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mode   <= MODE_OFF;
            r_cur_iv     <= '0;
            r_cur_du     <= '0;
            r_pend_valid <= 1'b0;
            r_pend_mode  <= MODE_OFF;
            r_pend_iv    <= '0;
            r_pend_du    <= '0;
            r_phase      <= 1'b0;
            r_step       <= '0;
            r_wait       <= '0;
            r_level      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_op)
                OP_WAIT_DEC: r_wait <= r_wait - 1'b1;
                OP_WAIT_CLR: r_wait <= '0;
                OP_SET_OFF: begin
                    r_phase <= 1'b1;
                    r_level <= '0;
                end
                OP_WAIT_Q: begin
                    r_wait <= (r_tq == '0) ? MS_W'(1) : r_tq;
                end
                OP_LEVEL_Q:  r_level <= LVL_W'(w_div_quot);
                OP_STEP_INC: r_step  <= r_step + 1'b1;
                OP_SET_TOP: begin
                    r_phase <= 1'b1;
                    r_step  <= r_cur_du;
                    r_level <= LVL_W'(LEVEL_FULL);
                end
                OP_STEP_DEC: begin
                    if (r_step != '0) begin
                        r_step <= r_step - 1'b1;
                    end
                end
                OP_PERIOD_END: begin
                    if (r_pend_valid) begin
                        r_pend_valid <= 1'b0;
                        r_cur_mode   <= r_pend_mode;
                        r_cur_iv     <= r_pend_iv;
                        r_cur_du     <= r_pend_du;
                    end
                end
                OP_ENTER: begin
                    r_phase <= 1'b0;
                    r_step  <= '0;
                    r_wait  <= '0;
                    unique case (t_mode'(r_cur_mode))
                        MODE_OFF:   r_level <= '0;
                        MODE_ON:    r_level <= LVL_W'(LEVEL_FULL);
                        MODE_BLINK: r_level <= LVL_W'(LEVEL_FULL);
                        MODE_FADE: begin
                            if (r_cur_du != '0) begin
                                r_level <= '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_STORE_PEND: begin
                    r_pend_valid <= 1'b1;
                    r_pend_mode  <= r_in_mode;
                    r_pend_iv    <= r_in_iv;
                    r_pend_du    <= r_in_du;
                end
                OP_LOAD_CUR: begin
                    r_cur_mode <= r_in_mode;
                    r_cur_iv   <= r_in_iv;
                    r_cur_du   <= r_in_du;
                end
                OP_WRITE_OUT: r_out_valid <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    assign o_stat.acc         = w_acc;
    assign o_stat.is_cmd      = r_in_op == OPC_CMD;
    assign o_stat.is_static   = r_cur_mode == MODE_OFF || r_cur_mode == MODE_ON;
    assign o_stat.wait_le1    = r_wait <= MS_W'(1);
    assign o_stat.is_fade     = r_cur_mode == MODE_FADE;
    assign o_stat.phase1      = r_phase;
    assign o_stat.div_busy    = w_div_busy;
    assign o_stat.dur_zero    = r_cur_du == '0;
    assign o_stat.step_ge_dur = r_step >= r_cur_du;
    assign o_stat.step_zero   = r_step == '0;
    assign o_stat.out_full    = r_out_valid && !o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.pwm_duty      = r_out_duty;
    assign o_out.level_percent = r_out_level;
    assign o_out.active_mode   = r_out_mode;
endmodule

FILE: rtl/led_pattern_controller_top.sv
// LED blink and fade controller. Each input word is a timer tick or a mode command (off, on,
// blink, fade with interval and duration in ms); each gives exactly one result word with the
// PWM duty, the level in percent and the running mode. Waits count ticks of TICK_MS ms, a zero
// wait lasting one tick. Commands during blink or fade are held, the latest winning, and take
// effect when the current period ends. A small microcode sequencer steps a plain datapath; a word
// that runs a fade step also waits on the 15-step serial divider, used once for the ramp level.
// A full output register adds its stall. A new word is taken while the previous result still
// waits in the output register.
module led_pattern_controller_top
    import lpc_pkg::*;
#(
    parameter int TICK_MS  = TICK_MS_DEF,
    parameter int DUTY_MAX = DUTY_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpc_in_if.sink    i_in,
    lpc_out_if.source o_out
);
    t_op   w_op;
    logic  w_idle;
    t_stat w_stat;

    lpc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_op    (w_op),
        .o_idle  (w_idle)
    );

    lpc_datapath #(
        .TICK_MS  (TICK_MS),
        .DUTY_MAX (DUTY_MAX)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_idle  (w_idle),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import lpc_pkg::*;

    localparam int TICK_LEN       = TICK_MS_DEF;
    localparam int DUTY_FULL      = DUTY_MAX_DEF;
    localparam int WORD_TARGET    = 1450;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 60;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [LVL_W-1:0]  pct;
        t_mode             mode;
    } led_word_t;

    logic i_clk;
    logic i_rst_n;

    lpc_in_if  word_in();
    lpc_out_if word_out();

    led_pattern_controller_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_in),
        .o_out   (word_out)
    );

    // predicted controller state
    t_mode           led_mode;
    logic [MS_W-1:0] led_iv;
    logic [MS_W-1:0] led_du;
    logic            pend_valid;
    t_mode           pend_mode;
    logic [MS_W-1:0] pend_iv;
    logic [MS_W-1:0] pend_du;
    logic            led_phase;
    logic [MS_W-1:0] led_step;
    logic [MS_W-1:0] led_wait;
    logic [LVL_W-1:0] led_level;

    led_word_t duty_words_q[$];
    int        mismatches;
    int        words_sent;
    int        idle_cycles;
    logic      idle_on;
    logic      hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [MS_W-1:0] wait_ticks(input logic [MS_W-1:0] ms);
        logic [MS_W-1:0] t;
        t = MS_W'(int'(ms) / TICK_LEN);
        return (t == '0) ? MS_W'(1) : t;
    endfunction

    function automatic logic [LVL_W-1:0] ramp_pct(input logic [MS_W-1:0] i,
                                                  input logic [MS_W-1:0] d);
        int p;
        p = (int'(i) * RAMP_SCALE) / int'(d);
        return p[LVL_W-1:0];
    endfunction

    function automatic void led_reset();
        led_mode   = MODE_OFF;
        led_iv     = '0;
        led_du     = '0;
        pend_valid = 1'b0;
        pend_mode  = MODE_OFF;
        pend_iv    = '0;
        pend_du    = '0;
        led_phase  = 1'b0;
        led_step   = '0;
        led_wait   = '0;
        led_level  = '0;
    endfunction

    function automatic void led_enter(input t_mode m, input logic [MS_W-1:0] iv,
                                      input logic [MS_W-1:0] du);
        led_mode  = m;
        led_iv    = iv;
        led_du    = du;
        led_phase = 1'b0;
        led_step  = '0;
        led_wait  = '0;
        case (m)
            MODE_OFF: led_level = '0;
            MODE_ON: led_level = LVL_W'(LEVEL_FULL);
            MODE_BLINK: begin
                led_level = LVL_W'(LEVEL_FULL);
                led_wait  = wait_ticks(du);
            end
            default: begin
                if (du != '0) begin
                    led_level = '0;
                    led_wait  = wait_ticks(iv);
                end
            end
        endcase
    endfunction

    function automatic void led_period_end();
        if (pend_valid) begin
            pend_valid = 1'b0;
            led_enter(pend_mode, pend_iv, pend_du);
        end else begin
            led_enter(led_mode, led_iv, led_du);
        end
    endfunction

    function automatic void led_tick();
        if (led_mode == MODE_OFF || led_mode == MODE_ON) begin
        end else if (led_wait > 1) begin
            led_wait = led_wait - 1'b1;
        end else begin
            led_wait = '0;
            if (led_mode == MODE_BLINK) begin
                if (!led_phase) begin
                    led_phase = 1'b1;
                    led_level = '0;
                    led_wait  = wait_ticks(led_iv);
                end else begin
                    led_period_end();
                end
            end else if (led_du == '0) begin
                led_period_end();
            end else if (!led_phase) begin
                led_step = led_step + 1'b1;
                if (led_step < led_du) begin
                    led_level = ramp_pct(led_step, led_du);
                end else begin
                    led_phase = 1'b1;
                    led_step  = led_du;
                    led_level = LVL_W'(LEVEL_FULL);
                end
                led_wait = wait_ticks(led_iv);
            end else begin
                if (led_step > '0) led_step = led_step - 1'b1;
                if (led_step > '0) begin
                    led_level = ramp_pct(led_step, led_du);
                    led_wait  = wait_ticks(led_iv);
                end else begin
                    led_period_end();
                end
            end
        end
    endfunction

    function automatic void predict_led(input t_opc opc, input t_mode m,
                                        input logic [MS_W-1:0] iv,
                                        input logic [MS_W-1:0] du);
        led_word_t w;
        int        d;
        if (opc == OPC_CMD) begin
            if (led_mode == MODE_OFF || led_mode == MODE_ON) begin
                led_enter(m, iv, du);
            end else begin
                pend_valid = 1'b1;
                pend_mode  = m;
                pend_iv    = iv;
                pend_du    = du;
            end
        end else begin
            led_tick();
        end
        d      = (DUTY_FULL * int'(led_level)) / LEVEL_FULL;
        w.duty = d[DUTY_W-1:0];
        w.pct  = led_level;
        w.mode = led_mode;
        duty_words_q.push_back(w);
    endfunction

    task automatic send_word(input t_opc opc, input t_mode m,
                             input logic [MS_W-1:0] iv, input logic [MS_W-1:0] du);
        int gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            word_in.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        word_in.opcode      = opc;
        word_in.mode_req    = m;
        word_in.interval_ms = iv;
        word_in.duration_ms = du;
        word_in.valid       = 1'b1;
        do @(posedge i_clk); while (!word_in.ready);
        predict_led(opc, m, iv, du);
        words_sent++;
    endtask

    // ticks carry random junk in the command fields
    task automatic send_tick();
        send_word(OPC_TICK, t_mode'($urandom_range(0, 3)), MS_W'($urandom), MS_W'($urandom));
    endtask

    task automatic send_cmd(input t_mode m, input logic [MS_W-1:0] iv,
                            input logic [MS_W-1:0] du);
        send_word(OPC_CMD, m, iv, du);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        word_in.valid = 1'b0;
        while (duty_words_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_pattern_cmd(input t_mode m);
        logic [MS_W-1:0] iv;
        logic [MS_W-1:0] du;
        iv = ($urandom_range(0, 4) != 0) ? MS_W'($urandom_range(0, 3))
                                         : MS_W'($urandom_range(4, 12));
        case (m)
            MODE_BLINK: du = MS_W'($urandom_range(0, 10));
            MODE_FADE: begin
                if ($urandom_range(0, 6) != 0) begin
                    du = MS_W'($urandom_range(0, 6));
                end else begin
                    du = MS_W'($urandom_range(7, 40));
                    iv = MS_W'($urandom_range(0, 1));
                end
            end
            default: begin
                iv = MS_W'($urandom);
                du = MS_W'($urandom);
            end
        endcase
        send_cmd(m, iv, du);
    endtask

    task automatic run_pattern();
        t_mode m;
        int    n_ticks;
        m = t_mode'($urandom_range(0, 3));
        // full-range command that only ever sits pending and gets overwritten
        if ((led_mode == MODE_BLINK || led_mode == MODE_FADE) && $urandom_range(0, 4) == 0)
            send_cmd(t_mode'($urandom_range(0, 3)), MS_W'($urandom), MS_W'($urandom));
        send_pattern_cmd(m);
        n_ticks = (led_mode == MODE_OFF || led_mode == MODE_ON) ? $urandom_range(1, 3)
                                                                : $urandom_range(4, 48);
        repeat (n_ticks) begin
            if ($urandom_range(0, 19) == 0) send_pattern_cmd(t_mode'($urandom_range(0, 3)));
            else send_tick();
        end
    endtask

    task automatic test_static_modes();
        idle_on = 1'b1;
        send_tick();
        send_cmd(MODE_ON, 15'h7FFF, 15'h7FFF);
        send_tick();
        send_cmd(MODE_OFF, '0, '0);
    endtask

    task automatic test_blink_cycle();
        send_cmd(MODE_BLINK, '0, '0);
        send_tick();
        send_tick();
    endtask

    task automatic test_fade_ramp();
        send_cmd(MODE_FADE, 15'd7, 15'd9);
        send_cmd(MODE_FADE, '0, 15'd3);
        send_tick();
        send_tick();
        send_cmd(MODE_FADE, 15'h7FFF, '0);
        repeat (6) send_tick();
        // zero duration keeps the last level
        send_tick();
        send_cmd(MODE_BLINK, 15'h7FFF, 15'h7FFF);
        send_cmd(MODE_ON, '0, '0);
        send_tick();
        send_cmd(MODE_OFF, '0, '0);
    endtask

    task automatic test_random_patterns(input int upto);
        while (words_sent < upto) begin
            idle_on = ($urandom_range(0, 3) != 0);
            run_pattern();
        end
    endtask

    task automatic test_output_stall();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (2) run_pattern();
    endtask

    task automatic test_drain_pause();
        idle_on = 1'b1;
        run_pattern();
        wait_drained();
        run_pattern();
    endtask

    initial begin : rx_side
        int stall;
        word_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                word_out.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, 13) : 0;
            if (stall > 0) begin
                word_out.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            word_out.ready = 1'b1;
            do @(posedge i_clk); while (!word_out.valid);
        end
    end

    always @(posedge i_clk) begin : check_words
        led_word_t got;
        led_word_t want;
        if (i_rst_n && word_out.valid && word_out.ready) begin
            got.duty = word_out.pwm_duty;
            got.pct  = word_out.level_percent;
            got.mode = t_mode'(word_out.active_mode);
            if (duty_words_q.size() == 0) begin
                $error("unexpected result word: duty %0d level %0d mode %0d",
                       got.duty, got.pct, got.mode);
                mismatches++;
            end else begin
                want = duty_words_q.pop_front();
                if (got.duty !== want.duty) begin
                    $error("pwm_duty: expected %0d, got %0d", want.duty, got.duty);
                    mismatches++;
                end
                if (got.pct !== want.pct) begin
                    $error("level_percent: expected %0d, got %0d", want.pct, got.pct);
                    mismatches++;
                end
                if (got.mode !== want.mode) begin
                    $error("active_mode: expected %0d, got %0d", want.mode, got.mode);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (word_in.valid && word_in.ready) || (word_out.valid && word_out.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("led_pattern_controller_top: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        word_in.valid       = 1'b0;
        word_in.opcode      = OPC_TICK;
        word_in.mode_req    = MODE_OFF;
        word_in.interval_ms = '0;
        word_in.duration_ms = '0;
        idle_on             = 1'b0;
        hold_req            = 1'b0;
        mismatches          = 0;
        words_sent          = 0;
        idle_cycles         = 0;
        led_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_static_modes();
        test_blink_cycle();
        test_fade_ramp();
        test_random_patterns(WORD_TARGET / 2);
        test_output_stall();
        test_drain_pause();
        test_random_patterns(WORD_TARGET);

        @(negedge i_clk);
        word_in.valid = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("led_pattern_controller_top: match");
        else
            $display("led_pattern_controller_top: mismatch");
        $finish;
    end

endmodule
